// ----- src/distance_sensor_occupancy_tracker_core_macros.svh -----
// Assertion macros for the checker module of the tracker.
`ifndef DISTANCE_SENSOR_OCCUPANCY_TRACKER_CORE_MACROS_SVH
`define DISTANCE_SENSOR_OCCUPANCY_TRACKER_CORE_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DSOT_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define DSOT_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- src/dsot_pkg.sv -----
package dsot_pkg;

    // Field widths.
    localparam int unsigned SAMPLE_W    = 12;
    localparam int unsigned HUE_W       = 9;
    localparam int unsigned COLOR_W     = 2;
    localparam int unsigned COUNT_W     = 3;
    localparam int unsigned EVENT_W     = 2;
    localparam int unsigned MARGIN_W    = 10;
    localparam int unsigned COOL_W      = 8;
    localparam int unsigned PRESET_W    = 9;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned CFG_DATA_W  = 10;

    // The ring holds six items; pointers run 0..5.
    localparam int unsigned CAPACITY = 6;
    localparam int unsigned PTR_W    = 3;

    // Color codes.
    localparam logic [COLOR_W-1:0] COLOR_NONE = 2'd0;
    localparam logic [COLOR_W-1:0] COLOR_RED  = 2'd1;
    localparam logic [COLOR_W-1:0] COLOR_BLUE = 2'd2;

    // Event codes.
    localparam logic [EVENT_W-1:0] EVENT_NONE   = 2'd0;
    localparam logic [EVENT_W-1:0] EVENT_ADD    = 2'd1;
    localparam logic [EVENT_W-1:0] EVENT_REMOVE = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_INDEX_W-1:0] CFG_DEFAULT_COLOR = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_INC_MARGIN    = 8'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_DEC_MARGIN    = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_COOLDOWN      = 8'd3;

    // Reset values.
    localparam logic [SAMPLE_W-1:0] MID_RESET           = 12'd313;
    localparam logic [SAMPLE_W-1:0] TOP_RESET           = 12'd370;
    localparam logic [MARGIN_W-1:0] MARGIN_RESET        = 10'd60;
    localparam logic [COOL_W-1:0]   COOLDOWN_RESET      = 8'd12;
    localparam logic [COOL_W-1:0]   COOLDOWN_MAX        = 8'd255;
    localparam logic [COLOR_W-1:0]  DEFAULT_COLOR_RESET = COLOR_RED;

    // Hue boundaries in degrees.
    localparam logic [HUE_W-1:0] HUE_NONE     = 9'd340;
    localparam logic [HUE_W-1:0] HUE_RED_LOW  = 9'd30;
    localparam logic [HUE_W-1:0] HUE_BLUE_LOW = 9'd20;

    typedef struct packed {
        logic                tracking_enabled;
        logic [SAMPLE_W-1:0] mid_distance;
        logic [SAMPLE_W-1:0] top_distance;
        logic [HUE_W-1:0]    hue;
        logic                remove_from_top;
    } in_item_t;

    typedef struct packed {
        logic [EVENT_W-1:0] event_res;
        logic [COUNT_W-1:0] occupancy;
        logic [COLOR_W-1:0] top_color;
        logic [COUNT_W-1:0] top_run;
        logic [COLOR_W-1:0] front_color;
        logic [COUNT_W-1:0] front_run;
    } out_item_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_DECIDE,
        ST_LOAD,
        ST_FIRST,
        ST_WALK,
        ST_FINISH
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic capture;
        logic update;
        logic decide;
        logic load;
        logic first;
        logic walk;
        logic out_load;
    } ctrl_cmd_t;

    // Status back to the controller.
    typedef struct packed {
        logic walk_done;
        logic out_free;
    } ctrl_status_t;

    // Ring update decided for the current tick.
    typedef struct packed {
        logic               add;
        logic               rem;
        logic               from_top;
        logic [COLOR_W-1:0] color;
    } ring_op_t;

    // Middle sensor preset by occupancy.
    function automatic logic [PRESET_W-1:0] mid_preset(input logic [1:0] n);
        logic [PRESET_W-1:0] p;
        case (n)
            2'd0:    p = 9'd313;
            2'd1:    p = 9'd116;
            default: p = 9'd34;
        endcase
        return p;
    endfunction

    // Top sensor preset by step.
    function automatic logic [PRESET_W-1:0] top_preset(input logic [2:0] k);
        logic [PRESET_W-1:0] p;
        case (k)
            3'd0:    p = 9'd370;
            3'd1:    p = 9'd270;
            3'd2:    p = 9'd202;
            3'd3:    p = 9'd107;
            default: p = 9'd20;
        endcase
        return p;
    endfunction

endpackage

// ----- src/distance_sensor_occupancy_tracker_core.sv -----
// Occupancy tracker for a six-deep holder watched by a middle and a top distance sensor.
// Input channel (s_valid/s_ready/s_data): one request per sensor tick with both
// distance samples, the hue, the tracking flag and the removal end.
// Result channel (m_valid/m_ready/m_data): one request per tick with the event,
// the occupancy, and the color and run length at the head and tail ends.
// Configuration channel (cfg_valid/cfg_ready/cfg_index/cfg_data): cfg_ready is
// always high; indexes 0..3 select default color, add margin, remove margin and
// cooldown ticks. Other indexes are ignored. Write only while the block is idle.
// The run-length walk over the ring steps both ends at once through the ring memory's
// two read ports. One tick is in flight at a time: a new tick is accepted only once
// the result of the last one has been loaded into the output register.
// Reset (aresetn low, synchronous) restores the register defaults, fills both
// sample windows with their rest readings, empties the ring and restarts the
// cooldown. A stalled receiver holds the result in the output register; the next
// tick is still accepted and computed, and waits to be handed over.
module distance_sensor_occupancy_tracker_core #(
    parameter int WINDOW = 8
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  dsot_pkg::in_item_t                   s_data,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output dsot_pkg::out_item_t                  m_data,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [dsot_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [dsot_pkg::CFG_DATA_W-1:0]      cfg_data
);

    dsot_pkg::ctrl_cmd_t    cmd;
    dsot_pkg::ctrl_status_t status;
    dsot_pkg::ring_op_t     op;
    dsot_pkg::out_item_t    m_data_reg;
    logic                   m_valid_reg;

    logic [dsot_pkg::EVENT_W-1:0] event_res;
    logic [dsot_pkg::COUNT_W-1:0] ring_count;
    logic [dsot_pkg::COLOR_W-1:0] top_color;
    logic [dsot_pkg::COUNT_W-1:0] top_run;
    logic [dsot_pkg::COLOR_W-1:0] front_color;
    logic [dsot_pkg::COUNT_W-1:0] front_run;
    logic                         walk_done;

    assign cfg_ready        = 1'b1;
    assign status.walk_done = walk_done;
    assign status.out_free  = !m_valid_reg || m_ready;

    dsot_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .s_ready (s_ready),
        .cmd     (cmd)
    );

    dsot_sense #(
        .WINDOW (WINDOW)
    ) u_sense (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .s_data     (s_data),
        .cfg_valid  (cfg_valid),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .ring_count (ring_count),
        .op         (op),
        .event_res  (event_res)
    );

    dsot_ring u_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .op          (op),
        .count       (ring_count),
        .top_color   (top_color),
        .top_run     (top_run),
        .front_color (front_color),
        .front_run   (front_run),
        .walk_done   (walk_done)
    );

    // Output register between the datapath and the result channel.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            m_data_reg.event_res   <= event_res;
            m_data_reg.occupancy   <= ring_count;
            m_data_reg.top_color   <= top_color;
            m_data_reg.top_run     <= top_run;
            m_data_reg.front_color <= front_color;
            m_data_reg.front_run   <= front_run;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

endmodule

// ----- src/dsot_ctrl.sv -----
module dsot_ctrl (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_valid,
    input  dsot_pkg::ctrl_status_t  status,
    output logic                    s_ready,
    output dsot_pkg::ctrl_cmd_t     cmd
);

    dsot_pkg::state_t state_reg;
    dsot_pkg::state_t state_next;

    // State register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= dsot_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Next state.
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            dsot_pkg::ST_IDLE: begin
                if (s_valid) begin
                    state_next = dsot_pkg::ST_UPDATE;
                end
            end
            dsot_pkg::ST_UPDATE: state_next = dsot_pkg::ST_DECIDE;
            dsot_pkg::ST_DECIDE: state_next = dsot_pkg::ST_LOAD;
            dsot_pkg::ST_LOAD:   state_next = dsot_pkg::ST_FIRST;
            dsot_pkg::ST_FIRST:  state_next = dsot_pkg::ST_WALK;
            dsot_pkg::ST_WALK: begin
                if (status.walk_done) begin
                    state_next = dsot_pkg::ST_FINISH;
                end
            end
            dsot_pkg::ST_FINISH: begin
                if (status.out_free) begin
                    state_next = dsot_pkg::ST_IDLE;
                end
            end
            default: state_next = dsot_pkg::ST_IDLE;
        endcase
    end

    // Outputs per state.
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            dsot_pkg::ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            dsot_pkg::ST_UPDATE: cmd.update = 1'b1;
            dsot_pkg::ST_DECIDE: cmd.decide = 1'b1;
            dsot_pkg::ST_LOAD:   cmd.load   = 1'b1;
            dsot_pkg::ST_FIRST:  cmd.first  = 1'b1;
            dsot_pkg::ST_WALK:   cmd.walk   = 1'b1;
            dsot_pkg::ST_FINISH: cmd.out_load = status.out_free;
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- src/dsot_sense.sv -----
module dsot_sense #(
    parameter int WINDOW = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  dsot_pkg::ctrl_cmd_t                   cmd,
    input  dsot_pkg::in_item_t                    s_data,
    input  logic                                  cfg_valid,
    input  logic [dsot_pkg::CFG_INDEX_W-1:0]      cfg_index,
    input  logic [dsot_pkg::CFG_DATA_W-1:0]       cfg_data,
    input  logic [dsot_pkg::COUNT_W-1:0]          ring_count,
    output dsot_pkg::ring_op_t                    op,
    output logic [dsot_pkg::EVENT_W-1:0]          event_res
);

    localparam int IDX_W = $clog2(WINDOW);
    localparam int SUM_W = $clog2(WINDOW * ((1 << dsot_pkg::SAMPLE_W) - 1) + 1);
    localparam int EXT_W = SUM_W + 1;
    localparam int LIM_W = SUM_W + 2;

    localparam logic [SUM_W-1:0] MID_SUM_RESET = SUM_W'(WINDOW * dsot_pkg::MID_RESET);
    localparam logic [SUM_W-1:0] TOP_SUM_RESET = SUM_W'(WINDOW * dsot_pkg::TOP_RESET);
    localparam logic [IDX_W-1:0] IDX_LAST      = IDX_W'(WINDOW - 1);
    localparam logic signed [LIM_W-1:0] WIN_S  = LIM_W'(WINDOW);

    dsot_pkg::in_item_t in_reg;

    logic [dsot_pkg::SAMPLE_W-1:0] mid_win_reg [WINDOW];
    logic [dsot_pkg::SAMPLE_W-1:0] top_win_reg [WINDOW];
    logic [IDX_W-1:0]              idx_reg;
    logic [SUM_W-1:0]              mid_sum_reg;
    logic [SUM_W-1:0]              top_sum_reg;
    logic [SUM_W-1:0]              mid_sum_next;
    logic [SUM_W-1:0]              top_sum_next;

    logic [dsot_pkg::COOL_W-1:0]   cool_reg;
    logic [dsot_pkg::EVENT_W-1:0]  event_reg;

    logic [dsot_pkg::COLOR_W-1:0]  default_color_reg;
    logic [dsot_pkg::MARGIN_W-1:0] inc_margin_reg;
    logic [dsot_pkg::MARGIN_W-1:0] dec_margin_reg;
    logic [dsot_pkg::COOL_W-1:0]   cool_ticks_reg;

    logic [dsot_pkg::PRESET_W-1:0] add_preset;
    logic [dsot_pkg::PRESET_W-1:0] rem_preset;
    logic [SUM_W-1:0]              add_sum;
    logic [SUM_W-1:0]              rem_sum;
    logic                          add_en;
    logic                          rem_en;
    logic [2:0]                    step;

    logic signed [LIM_W-1:0] add_diff;
    logic signed [LIM_W-1:0] rem_diff;
    logic signed [LIM_W-1:0] add_lim;
    logic signed [LIM_W-1:0] rem_lim;
    logic                    is_below;
    logic                    is_above;
    logic                    cool_ok;
    logic                    add_fire;
    logic                    rem_fire;
    logic [dsot_pkg::COLOR_W-1:0] hue_color;

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            default_color_reg <= dsot_pkg::DEFAULT_COLOR_RESET;
            inc_margin_reg    <= dsot_pkg::MARGIN_RESET;
            dec_margin_reg    <= dsot_pkg::MARGIN_RESET;
            cool_ticks_reg    <= dsot_pkg::COOLDOWN_RESET;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                dsot_pkg::CFG_DEFAULT_COLOR: default_color_reg <= cfg_data[1:0];
                dsot_pkg::CFG_INC_MARGIN:    inc_margin_reg    <= cfg_data;
                dsot_pkg::CFG_DEC_MARGIN:    dec_margin_reg    <= cfg_data;
                dsot_pkg::CFG_COOLDOWN:      cool_ticks_reg    <= cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // Input item register.
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            in_reg <= s_data;
        end
    end

    // Running sums: drop the oldest sample and add the new one.
    assign mid_sum_next = SUM_W'(EXT_W'(mid_sum_reg) + EXT_W'(in_reg.mid_distance)
                                 - EXT_W'(mid_win_reg[idx_reg]));
    assign top_sum_next = SUM_W'(EXT_W'(top_sum_reg) + EXT_W'(in_reg.top_distance)
                                 - EXT_W'(top_win_reg[idx_reg]));

    // Sample windows and sums.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < WINDOW; i++) begin
                mid_win_reg[i] <= dsot_pkg::MID_RESET;
                top_win_reg[i] <= dsot_pkg::TOP_RESET;
            end
            idx_reg     <= '0;
            mid_sum_reg <= MID_SUM_RESET;
            top_sum_reg <= TOP_SUM_RESET;
        end else if (cmd.update && in_reg.tracking_enabled) begin
            mid_win_reg[idx_reg] <= in_reg.mid_distance;
            top_win_reg[idx_reg] <= in_reg.top_distance;
            mid_sum_reg          <= mid_sum_next;
            top_sum_reg          <= top_sum_next;
            idx_reg              <= (idx_reg == IDX_LAST) ? '0 : idx_reg + 1'b1;
        end
    end

    // Pick the sensor and preset for the add and remove tests by occupancy.
    always_comb begin
        step       = (ring_count >= 3'd6) ? 3'd4 : ring_count - 3'd2;
        add_sum    = top_sum_reg;
        rem_sum    = top_sum_reg;
        add_preset = dsot_pkg::top_preset(step);
        rem_preset = dsot_pkg::top_preset(step);
        add_en     = (ring_count < 3'(dsot_pkg::CAPACITY));
        rem_en     = 1'b1;
        if (ring_count < 3'd2) begin
            add_sum    = mid_sum_reg;
            rem_sum    = mid_sum_reg;
            add_preset = dsot_pkg::mid_preset(ring_count[1:0]);
            rem_preset = dsot_pkg::mid_preset(ring_count[1:0]);
            add_en     = 1'b1;
            rem_en     = (ring_count != 3'd0);
        end else if (ring_count == 3'd2) begin
            add_sum    = top_sum_reg;
            rem_sum    = mid_sum_reg;
            add_preset = dsot_pkg::top_preset(3'd0);
            rem_preset = dsot_pkg::mid_preset(2'd2);
            add_en     = 1'b1;
            rem_en     = 1'b1;
        end
    end

    // Compare the sums with WINDOW times the shifted presets, signed.
    assign add_diff = $signed(LIM_W'(add_preset)) - $signed(LIM_W'(inc_margin_reg));
    assign rem_diff = $signed(LIM_W'(rem_preset)) + $signed(LIM_W'(dec_margin_reg));
    assign add_lim  = add_diff * WIN_S;
    assign rem_lim  = rem_diff * WIN_S;
    assign is_below = $signed(LIM_W'(add_sum)) < add_lim;
    assign is_above = $signed(LIM_W'(rem_sum)) > rem_lim;
    assign cool_ok  = (cool_reg >= cool_ticks_reg);

    // An add is tested first; a removal only when no add fires.
    assign add_fire = in_reg.tracking_enabled && cool_ok && add_en && is_below;
    assign rem_fire = in_reg.tracking_enabled && cool_ok && rem_en && is_above && !add_fire;

    // Hue classification; exactly 340 degrees falls back to the default color.
    always_comb begin
        if (in_reg.hue > dsot_pkg::HUE_NONE || in_reg.hue < dsot_pkg::HUE_RED_LOW) begin
            hue_color = dsot_pkg::COLOR_RED;
        end else if (in_reg.hue > dsot_pkg::HUE_BLUE_LOW
                     && in_reg.hue < dsot_pkg::HUE_NONE) begin
            hue_color = dsot_pkg::COLOR_BLUE;
        end else if (default_color_reg == dsot_pkg::COLOR_BLUE) begin
            hue_color = dsot_pkg::COLOR_BLUE;
        end else begin
            hue_color = dsot_pkg::COLOR_RED;
        end
    end

    assign op.add      = cmd.decide && add_fire;
    assign op.rem      = cmd.decide && rem_fire;
    assign op.from_top = in_reg.remove_from_top;
    assign op.color    = hue_color;

    // Event code and cooldown counter, updated once per tick.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cool_reg  <= '0;
            event_reg <= dsot_pkg::EVENT_NONE;
        end else if (cmd.decide) begin
            if (add_fire) begin
                event_reg <= dsot_pkg::EVENT_ADD;
            end else if (rem_fire) begin
                event_reg <= dsot_pkg::EVENT_REMOVE;
            end else begin
                event_reg <= dsot_pkg::EVENT_NONE;
            end
            if (add_fire || rem_fire) begin
                cool_reg <= 8'd1;
            end else if (cool_reg != dsot_pkg::COOLDOWN_MAX) begin
                cool_reg <= cool_reg + 1'b1;
            end
        end
    end

    assign event_res = event_reg;

endmodule

// ----- src/dsot_ring.sv -----
module dsot_ring (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  dsot_pkg::ctrl_cmd_t           cmd,
    input  dsot_pkg::ring_op_t            op,
    output logic [dsot_pkg::COUNT_W-1:0]  count,
    output logic [dsot_pkg::COLOR_W-1:0]  top_color,
    output logic [dsot_pkg::COUNT_W-1:0]  top_run,
    output logic [dsot_pkg::COLOR_W-1:0]  front_color,
    output logic [dsot_pkg::COUNT_W-1:0]  front_run,
    output logic                          walk_done
);

    localparam int unsigned PTR_W = dsot_pkg::PTR_W;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(dsot_pkg::CAPACITY - 1);

    logic [dsot_pkg::COLOR_W-1:0] ring_mem [dsot_pkg::CAPACITY];

    logic [PTR_W-1:0]             head_reg;
    logic [dsot_pkg::COUNT_W-1:0] count_reg;
    logic [PTR_W-1:0]             wr_addr;
    logic [PTR_W-1:0]             tail;
    logic [PTR_W-1:0]             addr_a;
    logic [PTR_W-1:0]             addr_b;
    logic [PTR_W-1:0]             pos_a_reg;
    logic [PTR_W-1:0]             pos_b_reg;
    logic [dsot_pkg::COLOR_W-1:0] rd_a_reg;
    logic [dsot_pkg::COLOR_W-1:0] rd_b_reg;

    logic [dsot_pkg::COLOR_W-1:0] top_color_reg;
    logic [dsot_pkg::COLOR_W-1:0] front_color_reg;
    logic [dsot_pkg::COUNT_W-1:0] top_run_reg;
    logic [dsot_pkg::COUNT_W-1:0] front_run_reg;
    logic                         act_a_reg;
    logic                         act_b_reg;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        return (p == PTR_LAST) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PTR_W-1:0] ptr_dec(input logic [PTR_W-1:0] p);
        return (p == '0) ? PTR_LAST : p - 1'b1;
    endfunction

    // Reduce a sum below three times the capacity to a ring position.
    function automatic logic [PTR_W-1:0] ptr_wrap(input logic [4:0] v);
        logic [4:0] r;
        if (v >= 5'(2 * dsot_pkg::CAPACITY)) begin
            r = v - 5'(2 * dsot_pkg::CAPACITY);
        end else if (v >= 5'(dsot_pkg::CAPACITY)) begin
            r = v - 5'(dsot_pkg::CAPACITY);
        end else begin
            r = v;
        end
        return r[PTR_W-1:0];
    endfunction

    assign wr_addr = ptr_wrap(5'(head_reg) + 5'(count_reg));
    assign tail    = ptr_wrap(5'(head_reg) + 5'(count_reg) + 5'(dsot_pkg::CAPACITY - 1));

    // Head pointer and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            head_reg  <= '0;
            count_reg <= '0;
        end else if (op.add) begin
            count_reg <= count_reg + 1'b1;
        end else if (op.rem) begin
            count_reg <= count_reg - 1'b1;
            if (op.from_top) begin
                head_reg <= ptr_inc(head_reg);
            end
        end
    end

    // Walk addresses: start at both ends, then step inward one entry a cycle.
    assign addr_a = cmd.load ? head_reg : ptr_inc(pos_a_reg);
    assign addr_b = cmd.load ? tail     : ptr_dec(pos_b_reg);

    // Ring memory: one write port, two registered read ports.
    always_ff @(posedge aclk) begin
        if (op.add) begin
            ring_mem[wr_addr] <= op.color;
        end
        rd_a_reg  <= ring_mem[addr_a];
        rd_b_reg  <= ring_mem[addr_b];
        pos_a_reg <= addr_a;
        pos_b_reg <= addr_b;
    end

    // End colors and run lengths.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            act_a_reg       <= 1'b0;
            act_b_reg       <= 1'b0;
            top_color_reg   <= dsot_pkg::COLOR_NONE;
            front_color_reg <= dsot_pkg::COLOR_NONE;
            top_run_reg     <= '0;
            front_run_reg   <= '0;
        end else if (cmd.first) begin
            if (count_reg == '0) begin
                top_color_reg   <= dsot_pkg::COLOR_NONE;
                front_color_reg <= dsot_pkg::COLOR_NONE;
                top_run_reg     <= '0;
                front_run_reg   <= '0;
            end else begin
                top_color_reg   <= rd_a_reg;
                front_color_reg <= rd_b_reg;
                top_run_reg     <= 3'd1;
                front_run_reg   <= 3'd1;
            end
            act_a_reg <= (count_reg > 3'd1);
            act_b_reg <= (count_reg > 3'd1);
        end else if (cmd.walk) begin
            if (act_a_reg) begin
                if (rd_a_reg == top_color_reg) begin
                    top_run_reg <= top_run_reg + 1'b1;
                    act_a_reg   <= ((top_run_reg + 3'd1) < count_reg);
                end else begin
                    act_a_reg <= 1'b0;
                end
            end
            if (act_b_reg) begin
                if (rd_b_reg == front_color_reg) begin
                    front_run_reg <= front_run_reg + 1'b1;
                    act_b_reg     <= ((front_run_reg + 3'd1) < count_reg);
                end else begin
                    act_b_reg <= 1'b0;
                end
            end
        end
    end

    assign walk_done   = !act_a_reg && !act_b_reg;
    assign count       = count_reg;
    assign top_color   = top_color_reg;
    assign top_run     = top_run_reg;
    assign front_color = front_color_reg;
    assign front_run   = front_run_reg;

endmodule

// ----- src/dsot_checker.sv -----
`include "distance_sensor_occupancy_tracker_core_macros.svh"

module dsot_checker (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    input  logic                 s_ready,
    input  logic                 m_valid,
    input  logic                 m_ready,
    input  dsot_pkg::out_item_t  m_data
);

    // A stalled result stays offered and unchanged.
    `DSOT_ASSERT_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_data), "result dropped or changed while stalled")

    // Ticks are processed one at a time: no request is taken right after another.
    `DSOT_ASSERT_NEXT(a_one_tick, aclk, aresetn, s_valid && s_ready, !s_ready, "input accepted while a tick was in flight")

    // An empty ring reports no colors and no runs.
    `DSOT_ASSERT_SAME(a_empty_report, aclk, aresetn, m_valid && (m_data.occupancy == 3'd0), (m_data.top_color == dsot_pkg::COLOR_NONE) && (m_data.front_color == dsot_pkg::COLOR_NONE) && (m_data.top_run == 3'd0) && (m_data.front_run == 3'd0), "empty ring reports colors or runs")

    // Runs of a non-empty ring are at least one and never exceed the occupancy.
    `DSOT_ASSERT_SAME(a_run_bounds, aclk, aresetn, m_valid && (m_data.occupancy != 3'd0), (m_data.top_run != 3'd0) && (m_data.front_run != 3'd0) && (m_data.top_run <= m_data.occupancy) && (m_data.front_run <= m_data.occupancy), "run length out of range")

endmodule

bind distance_sensor_occupancy_tracker_core dsot_checker u_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ----- tb/dsot_occupancy_checker.sv -----
`timescale 1ns / 100ps

module dsot_occupancy_checker
    import dsot_pkg::*;
#(
    parameter int WINDOW = 8
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    input  logic                   s_ready,
    input  in_item_t               s_data,
    input  logic                   m_valid,
    input  logic                   m_ready,
    input  out_item_t              m_data,
    input  logic                   cfg_valid,
    input  logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   run_done,
    output int                     mismatch_count,
    output int                     reports_waiting
);

    // Settings as last written.
    logic [COLOR_W-1:0]  fill_color;
    logic [MARGIN_W-1:0] add_margin;
    logic [MARGIN_W-1:0] drop_margin;
    logic [COOL_W-1:0]   quiet_ticks;

    // Holder contents, sample history and cooldown.
    logic [COLOR_W-1:0]  slot_color [CAPACITY];
    logic [PTR_W-1:0]    head_pos;
    logic [COUNT_W-1:0]  held;
    logic [SAMPLE_W-1:0] mid_hist [WINDOW];
    logic [SAMPLE_W-1:0] top_hist [WINDOW];
    logic [PTR_W-1:0]    hist_pos;
    logic [14:0]         mid_total;
    logic [14:0]         top_total;
    logic [COOL_W-1:0]   since_event;

    // Reports predicted for accepted ticks, oldest first.
    out_item_t predicted_reports [$];
    out_item_t predicted;
    out_item_t want;
    logic      leftovers_checked = 1'b0;

    // Rest reading of the middle sensor with n items held.
    function automatic int mid_rest(input int n);
        case (n)
            0:       return 313;
            1:       return 116;
            default: return 34;
        endcase
    endfunction

    // Rest reading of the top sensor at step k.
    function automatic int top_rest(input int k);
        case (k)
            0:       return 370;
            1:       return 270;
            2:       return 202;
            3:       return 107;
            default: return 20;
        endcase
    endfunction

    // The average is below the rest reading minus the margin, kept exact on the sum.
    function automatic logic under_limit(input logic [14:0] total, input int rest,
                                         input logic [MARGIN_W-1:0] margin);
        return int'(total) < WINDOW * (rest - int'(margin));
    endfunction

    function automatic logic over_limit(input logic [14:0] total, input int rest,
                                        input logic [MARGIN_W-1:0] margin);
        return int'(total) > WINDOW * (rest + int'(margin));
    endfunction

    // Hue 340 alone has no color; the red band wraps around zero.
    function automatic logic [COLOR_W-1:0] hue_color(input logic [HUE_W-1:0] hue);
        if (hue > HUE_NONE || hue < HUE_RED_LOW) return COLOR_RED;
        if (hue > HUE_BLUE_LOW && hue < HUE_NONE) return COLOR_BLUE;
        return COLOR_NONE;
    endfunction

    // Length of the run of equal colors starting at one end of the holder.
    function automatic int run_length(input int start, input logic forward);
        int pos;
        int nxt;
        int run;
        pos = start;
        run = 1;
        while (run < held) begin
            nxt = forward ? (pos + 1) % CAPACITY : (pos + CAPACITY - 1) % CAPACITY;
            if (slot_color[nxt] != slot_color[start]) break;
            pos = nxt;
            run++;
        end
        return run;
    endfunction

    function automatic string show(input out_item_t r);
        return $sformatf("event %0d occupancy %0d top %0d x%0d front %0d x%0d",
                         r.event_res, r.occupancy, r.top_color, r.top_run,
                         r.front_color, r.front_run);
    endfunction

    task automatic report_mismatch(input string what);
        mismatch_count++;
        $display("%0t ns: occupancy mismatch: %s", $time, what);
    endtask

    // Advance the tracker by one sensor tick and work out its report.
    task automatic track_tick(input in_item_t tick, output out_item_t res);
        logic               armed;
        logic               add_it;
        logic               drop_it;
        int                 n;
        int                 slot;
        int                 tail;
        logic [COLOR_W-1:0] color;
        logic [EVENT_W-1:0] ev;
        armed = since_event >= quiet_ticks;
        add_it = 1'b0;
        drop_it = 1'b0;
        ev = EVENT_NONE;
        n = int'(held);
        if (tick.tracking_enabled) begin
            slot = int'(hist_pos);
            mid_total = mid_total - mid_hist[slot] + tick.mid_distance;
            mid_hist[slot] = tick.mid_distance;
            top_total = top_total - top_hist[slot] + tick.top_distance;
            top_hist[slot] = tick.top_distance;
            hist_pos = PTR_W'((slot + 1) % WINDOW);

            // The sensor and rest reading that decide depend on how many items are held.
            if (n < 2) begin
                add_it = armed && under_limit(mid_total, mid_rest(n), add_margin);
                drop_it = !add_it && armed && n > 0 &&
                          over_limit(mid_total, mid_rest(n), drop_margin);
            end else if (n == 2) begin
                add_it = armed && under_limit(top_total, top_rest(0), add_margin);
                drop_it = !add_it && armed && over_limit(mid_total, mid_rest(2), drop_margin);
            end else begin
                add_it = armed && n < CAPACITY &&
                         under_limit(top_total, top_rest(n - 2), add_margin);
                drop_it = !add_it && armed &&
                          over_limit(top_total, top_rest(n - 2), drop_margin);
            end

            if (add_it) begin
                color = hue_color(tick.hue);
                if (color == COLOR_NONE)
                    color = (fill_color == COLOR_BLUE) ? COLOR_BLUE : COLOR_RED;
                slot_color[(head_pos + held) % CAPACITY] = color;
                held = held + 1'b1;
                ev = EVENT_ADD;
            end else if (drop_it) begin
                if (tick.remove_from_top) head_pos = PTR_W'((head_pos + 1) % CAPACITY);
                held = held - 1'b1;
                ev = EVENT_REMOVE;
            end
        end

        // The cooldown counter runs every tick and restarts on an event.
        if (ev != EVENT_NONE) since_event = COOL_W'(1);
        else if (since_event != COOLDOWN_MAX) since_event = since_event + 1'b1;

        res = '0;
        res.event_res = ev;
        res.occupancy = held;
        if (held != 0) begin
            tail = int'((head_pos + held - 1) % CAPACITY);
            res.top_color = slot_color[head_pos];
            res.top_run = COUNT_W'(run_length(int'(head_pos), 1'b1));
            res.front_color = slot_color[tail];
            res.front_run = COUNT_W'(run_length(tail, 1'b0));
        end
    endtask

    // Watch all three channels: settings, ticks in, reports out.
    always @(posedge aclk) begin
        if (!aresetn) begin
            fill_color = DEFAULT_COLOR_RESET;
            add_margin = MARGIN_RESET;
            drop_margin = MARGIN_RESET;
            quiet_ticks = COOLDOWN_RESET;
            for (int i = 0; i < CAPACITY; i++) slot_color[i] = COLOR_NONE;
            for (int i = 0; i < WINDOW; i++) begin
                mid_hist[i] = MID_RESET;
                top_hist[i] = TOP_RESET;
            end
            head_pos = '0;
            held = '0;
            hist_pos = '0;
            mid_total = 15'(WINDOW * MID_RESET);
            top_total = 15'(WINDOW * TOP_RESET);
            since_event = '0;
            predicted_reports.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (predicted_reports.size() == 0) begin
                    report_mismatch($sformatf("%s with no tick pending", show(m_data)));
                end else begin
                    want = predicted_reports.pop_front();
                    if (m_data !== want)
                        report_mismatch($sformatf("got %s, expected %s",
                                                  show(m_data), show(want)));
                end
            end

            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_DEFAULT_COLOR: fill_color = cfg_data[COLOR_W-1:0];
                    CFG_INC_MARGIN:    add_margin = cfg_data[MARGIN_W-1:0];
                    CFG_DEC_MARGIN:    drop_margin = cfg_data[MARGIN_W-1:0];
                    CFG_COOLDOWN:      quiet_ticks = cfg_data[COOL_W-1:0];
                    default: ;
                endcase
            end

            if (s_valid && s_ready) begin
                track_tick(s_data, predicted);
                predicted_reports.push_back(predicted);
            end

            // Anything still predicted once the run is over never arrived.
            if (run_done && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (predicted_reports.size() != 0)
                    report_mismatch($sformatf("%0d reports never delivered",
                                              predicted_reports.size()));
            end
        end
        reports_waiting <= predicted_reports.size();
    end

endmodule

// ----- tb/distance_sensor_occupancy_tracker_core_tb.sv -----
`timescale 1ns / 100ps

module distance_sensor_occupancy_tracker_core_tb;
    import dsot_pkg::*;

    localparam int CLK_PERIOD      = 8;
    localparam int RESET_CYCLES    = 8;
    localparam int DRAIN_CYCLES    = 24;
    localparam int IDLE_LIMIT      = 1000;
    localparam int RANDOM_PHASES   = 8;
    localparam int TICKS_PER_PHASE = 125;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_W) - 1;
    localparam int HUE_MAX         = (1 << HUE_W) - 1;
    localparam int MARGIN_MAX      = (1 << MARGIN_W) - 1;
    localparam int CFG_DATA_MAX    = (1 << CFG_DATA_W) - 1;
    localparam int CFG_INDEX_MAX   = (1 << CFG_INDEX_W) - 1;
    localparam logic [COLOR_W-1:0] COLOR_ODD = 2'd3;

    typedef enum int {
        READY_FREE,
        READY_RANDOM,
        READY_HELD_OFF
    } ready_mode_t;

    logic                   aclk = 1'b0;
    logic                   aresetn = 1'b0;
    logic                   s_valid = 1'b0;
    logic                   s_ready;
    in_item_t               s_data = '0;
    logic                   m_valid;
    logic                   m_ready = 1'b0;
    out_item_t              m_data;
    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   run_done = 1'b0;
    int                     mismatch_count;
    int                     reports_waiting;
    int                     idle_cycles = 0;

    // Sender bursts and the slowly moving sensor levels.
    int burst_left = 0;
    int level_step = 0;
    int level_left = 0;
    int mid_level = 313;
    int top_level = 370;
    int border_hues [11] = '{0, 19, 20, 21, 29, 30, 31, 339, 340, 341, 359};
    int fill_hues [10] = '{0, 29, 30, 339, 340, 341, 511, 20, 21, 359};

    always #(CLK_PERIOD / 2) aclk = ~aclk;

    distance_sensor_occupancy_tracker_core u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    dsot_occupancy_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_data          (s_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_data          (m_data),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .run_done        (run_done),
        .mismatch_count  (mismatch_count),
        .reports_waiting (reports_waiting)
    );

    // End the run when no request has moved on any channel for too long.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (cfg_valid && cfg_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles == IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // The receiver alternates free stretches, random stalls and hold-offs.
    initial begin : receiver_pattern
        ready_mode_t mode;
        int          span;
        forever begin
            mode = ready_mode_t'($urandom_range(0, 2));
            span = (mode == READY_HELD_OFF) ? $urandom_range(1, 20) : $urandom_range(4, 40);
            repeat (span) begin
                @(posedge aclk);
                case (mode)
                    READY_FREE:   m_ready <= 1'b1;
                    READY_RANDOM: m_ready <= ($urandom_range(0, 3) != 0);
                    default:      m_ready <= 1'b0;
                endcase
            end
        end
    end

    function automatic int clamp_mm(input int v);
        return (v < 0) ? 0 : (v > SAMPLE_MAX) ? SAMPLE_MAX : v;
    endfunction

    function automatic in_item_t tick_of(input logic en, input int mid, input int top,
                                         input int hue, input logic from_top);
        in_item_t t;
        t.tracking_enabled = en;
        t.mid_distance = mid[SAMPLE_W-1:0];
        t.top_distance = top[SAMPLE_W-1:0];
        t.hue = hue[HUE_W-1:0];
        t.remove_from_top = from_top;
        return t;
    endfunction

    function automatic int draw_margin();
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, MARGIN_MAX)
                                           : $urandom_range(0, 120);
    endfunction

    // Offer one tick request, opening a random gap at the start of most bursts.
    task automatic send_tick(input in_item_t tick);
        if (burst_left == 0) begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            if ($urandom_range(0, 3) != 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 15)) @(posedge aclk);
            end
        end
        burst_left--;
        s_data  <= tick;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] index,
                                  input logic [CFG_DATA_W-1:0] value);
        cfg_index <= index;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
    endtask

    // Stop offering ticks and wait until every report is out and the block is quiet.
    task automatic settle();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (reports_waiting != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input int color, input int margin_add,
                                  input int margin_drop, input int quiet);
        settle();
        write_register(CFG_DEFAULT_COLOR, color[CFG_DATA_W-1:0]);
        write_register(CFG_INC_MARGIN, margin_add[CFG_DATA_W-1:0]);
        write_register(CFG_DEC_MARGIN, margin_drop[CFG_DATA_W-1:0]);
        write_register(CFG_COOLDOWN, quiet[CFG_DATA_W-1:0]);
        // An index past the last register must be ignored.
        write_register(CFG_INDEX_W'($urandom_range(CFG_COOLDOWN + 1, CFG_INDEX_MAX)),
                       CFG_DATA_W'($urandom_range(0, CFG_DATA_MAX)));
        cfg_valid <= 1'b0;
    endtask

    // Mostly readings that hover around the level of some number of items held,
    // moving one item at a time, with some noise requests in between.
    task automatic random_tick(output in_item_t tick);
        int mid_base;
        int top_base;
        if (level_left == 0) begin
            if ($urandom_range(0, 9) == 0) level_step = $urandom_range(0, CAPACITY);
            else if (level_step == 0) level_step = 1;
            else if (level_step == CAPACITY) level_step = CAPACITY - 1;
            else level_step = ($urandom_range(0, 1) != 0) ? level_step + 1 : level_step - 1;
            case (level_step)
                0:       begin mid_base = 313; top_base = 370; end
                1:       begin mid_base = 116; top_base = 370; end
                2:       begin mid_base = 34;  top_base = 370; end
                3:       begin mid_base = 34;  top_base = 270; end
                4:       begin mid_base = 34;  top_base = 202; end
                5:       begin mid_base = 34;  top_base = 107; end
                default: begin mid_base = 34;  top_base = 20;  end
            endcase
            mid_level = clamp_mm(mid_base + int'($urandom_range(0, 60)) - 30);
            top_level = clamp_mm(top_base + int'($urandom_range(0, 60)) - 30);
            level_left = $urandom_range(6, 30);
        end
        level_left--;
        if ($urandom_range(0, 9) == 0) begin
            tick.tracking_enabled = 1'($urandom_range(0, 1));
            tick.mid_distance = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            tick.top_distance = SAMPLE_W'($urandom_range(0, SAMPLE_MAX));
            tick.hue = HUE_W'($urandom_range(0, HUE_MAX));
        end else begin
            tick.tracking_enabled = ($urandom_range(0, 19) != 0);
            tick.mid_distance = SAMPLE_W'(clamp_mm(mid_level + int'($urandom_range(0, 16)) - 8));
            tick.top_distance = SAMPLE_W'(clamp_mm(top_level + int'($urandom_range(0, 16)) - 8));
            case ($urandom_range(0, 9))
                0, 1:    tick.hue = HUE_W'(border_hues[$urandom_range(0, 10)]);
                2:       tick.hue = HUE_W'($urandom_range(0, HUE_MAX));
                default: tick.hue = HUE_W'($urandom_range(0, 359));
            endcase
        end
        tick.remove_from_top = 1'($urandom_range(0, 1));
    endtask

    initial begin : stimulus
        in_item_t tick;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset settings: the cooldown keeps the first ticks quiet.
        send_tick(tick_of(1'b0, SAMPLE_MAX, SAMPLE_MAX, HUE_MAX, 1'b1));
        send_tick(tick_of(1'b1, 313, 370, 0, 1'b0));
        send_tick(tick_of(1'b1, 0, 0, 340, 1'b1));

        // No cooldown and no margins: zero readings fill the holder to the top,
        // with the hues at the color borders, then one tick with tracking off.
        apply_settings(COLOR_BLUE, 0, 0, 0);
        foreach (fill_hues[i]) send_tick(tick_of(1'b1, 0, 0, fill_hues[i], 1'b0));
        send_tick(tick_of(1'b0, 0, 0, 340, 1'b0));

        // Maximum readings empty it again from alternating ends.
        for (int i = 0; i < 7; i++)
            send_tick(tick_of(1'b1, SAMPLE_MAX, SAMPLE_MAX, 100, i[0]));

        // Random phases: reset values, both extremes, then random settings.
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            case (phase)
                0: apply_settings(COLOR_RED, MARGIN_RESET, MARGIN_RESET, COOLDOWN_RESET);
                1: apply_settings(COLOR_ODD, MARGIN_MAX, MARGIN_MAX, COOLDOWN_MAX);
                2: apply_settings(COLOR_NONE, 0, 0, 0);
                default: apply_settings($urandom_range(0, CFG_DATA_MAX), draw_margin(),
                                        draw_margin(),
                                        ($urandom_range(0, 7) == 0) ?
                                            $urandom_range(0, CFG_DATA_MAX) :
                                            $urandom_range(0, 20));
            endcase
            repeat (TICKS_PER_PHASE) begin
                random_tick(tick);
                send_tick(tick);
            end
        end

        settle();
        run_done <= 1'b1;
        repeat (2) @(posedge aclk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
